// ===== rtl/uqt_pkg.sv =====
// Package for the URL query tokenizer: payload structs, field codes,
// parser enums and the step-to-queue result bundle. No dependencies.
`default_nettype none

package uqt_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_target;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] field_kind;
    logic [1:0] pair_status;
    logic       last_of_item;
    logic       target_done;
  } out_t;

  // field_kind codes
  localparam logic [1:0] KIND_PATH  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;
  localparam logic [1:0] KIND_MARK  = 2'd3;

  // pair_status codes
  localparam logic [1:0] ST_KEPT    = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // delimiter bytes
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_PATH  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_e;

  // up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    out_t       r0;
    out_t       r1;
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/url_query_tokenizer.sv =====
// Top level of the URL query tokenizer: input register, parser step and
// result queue. Depends on uqt_pkg, uqt_step and uqt_res_queue.
//
//   channel | signals                               | payload
//   input   | in_valid_i, in_ready_o, in_data_i     | uqt_pkg::in_t
//   output  | out_valid_o, out_ready_i, out_data_o  | uqt_pkg::out_t
//
// One input transfer per cycle while the output is not stalled and each byte
// yields at most one result. A byte yielding two results (data byte plus
// pair end marker at end of target) leaves as two transfers, held by the
// three-entry result queue. Registered in order: input register, queue.
// Reset clears the parser state and both valid flags; no clearing pass.
// A stalled output fills the queue, then holds the input register.
`default_nettype none

module url_query_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  uqt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output uqt_pkg::out_t out_data_o
);
  import uqt_pkg::*;

  in_t       in_q;
  logic      in_valid_q;
  logic      room;
  logic      fire;
  step_res_t res;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  uqt_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_q),
    .res_o  (res)
  );

  uqt_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/uqt_step.sv =====
// Parser step: holds the tokenizer state and turns one registered input
// byte into up to two results. Depends on uqt_pkg.
`default_nettype none

module uqt_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  uqt_pkg::in_t      in_i,
  output uqt_pkg::step_res_t res_o
);
  import uqt_pkg::*;

  phase_e     ph_q, ph_d, ph_mid;
  esc_e       es_q, es_d, es_mid;
  logic [3:0] hn_q, hn_d, hn_mid;
  logic       ne_q, ne_d, ne_mid;
  logic       eq_q, eq_d, eq_mid;
  logic       bad_q, bad_d, bad_mid;

  logic [7:0] c;
  logic       last;
  logic       hex_ok;
  logic [3:0] hex_nib;
  logic [1:0] cur_kind;
  logic       has_byte;
  logic [7:0] byte_val;
  logic [1:0] byte_kind;
  logic       do_close;
  logic       has_mark;
  logic [1:0] mark_status;
  out_t       byte_res, mark_res;

  assign c    = in_i.in_byte;
  assign last = in_i.end_of_target;

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_nib = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cur_kind = (ph_q == PH_KEY) ? KIND_KEY : KIND_VALUE;

  // byte handling before any pair close
  always_comb begin
    ph_mid    = ph_q;
    es_mid    = es_q;
    hn_mid    = hn_q;
    ne_mid    = ne_q;
    eq_mid    = eq_q;
    bad_mid   = bad_q;
    has_byte  = 1'b0;
    byte_val  = c;
    byte_kind = cur_kind;
    do_close  = 1'b0;
    if (ph_q == PH_PATH) begin
      if (c == CH_QUEST) begin
        ph_mid  = PH_KEY;
        es_mid  = ESC_NONE;
        hn_mid  = 4'd0;
        ne_mid  = 1'b0;
        eq_mid  = 1'b0;
        bad_mid = 1'b0;
      end else begin
        has_byte  = 1'b1;
        byte_kind = KIND_PATH;
      end
    end else if (c == CH_AMP) begin
      do_close = 1'b1;
      ph_mid   = PH_KEY;
    end else begin
      ne_mid = 1'b1;
      if (ph_q == PH_KEY && c == CH_EQ) begin
        if (es_q != ESC_NONE) bad_mid = 1'b1;
        es_mid = ESC_NONE;
        eq_mid = 1'b1;
        ph_mid = PH_VALUE;
      end else if (es_q == ESC_FIRST) begin
        if (!hex_ok) begin
          bad_mid = 1'b1;
          es_mid  = ESC_NONE;
        end else begin
          hn_mid = hex_nib;
          es_mid = ESC_SECOND;
        end
      end else if (es_q != ESC_NONE) begin
        es_mid = ESC_NONE;
        if (!hex_ok) begin
          bad_mid = 1'b1;
        end else begin
          has_byte = 1'b1;
          byte_val = {hn_q, hex_nib};
        end
      end else if (c == CH_PCT) begin
        es_mid = ESC_FIRST;
      end else if (c == CH_PLUS) begin
        has_byte = 1'b1;
        byte_val = CH_SPACE;
      end else begin
        has_byte = 1'b1;
      end
    end
    if (last && ph_mid != PH_PATH) do_close = 1'b1;
  end

  // pair close, then end-of-target reset
  always_comb begin
    has_mark    = do_close && ne_mid;
    mark_status = ST_KEPT;
    if (!eq_mid) begin
      mark_status = ST_DROPPED;
    end else if (bad_mid || es_mid != ESC_NONE) begin
      mark_status = ST_BAD;
    end
    ph_d  = ph_mid;
    es_d  = es_mid;
    hn_d  = hn_mid;
    ne_d  = ne_mid;
    eq_d  = eq_mid;
    bad_d = bad_mid;
    if (do_close || last) begin
      es_d  = ESC_NONE;
      hn_d  = 4'd0;
      ne_d  = 1'b0;
      eq_d  = 1'b0;
      bad_d = 1'b0;
    end
    if (last) ph_d = PH_PATH;
  end

  always_comb begin
    byte_res              = '0;
    byte_res.out_byte     = byte_val;
    byte_res.field_kind   = byte_kind;
    byte_res.pair_status  = ST_KEPT;
    byte_res.last_of_item = !has_mark;
    byte_res.target_done  = !has_mark && last;

    mark_res              = '0;
    mark_res.out_byte     = 8'd0;
    mark_res.field_kind   = KIND_MARK;
    mark_res.pair_status  = mark_status;
    mark_res.last_of_item = 1'b1;
    mark_res.target_done  = last;

    res_o.count = {1'b0, has_byte} + {1'b0, has_mark};
    res_o.r0    = has_byte ? byte_res : mark_res;
    res_o.r1    = mark_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_PATH;
      es_q  <= ESC_NONE;
      hn_q  <= 4'd0;
      ne_q  <= 1'b0;
      eq_q  <= 1'b0;
      bad_q <= 1'b0;
    end else if (fire_i) begin
      ph_q  <= ph_d;
      es_q  <= es_d;
      hn_q  <= hn_d;
      ne_q  <= ne_d;
      eq_q  <= eq_d;
      bad_q <= bad_d;
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && in_i.end_of_target) |=> (ph_q == PH_PATH && es_q == ESC_NONE && !ne_q))
    else $error("state not cleared after end of target");

  a_two_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.count == 2'd2) |->
      (!res_o.r0.last_of_item && res_o.r1.last_of_item && res_o.r1.field_kind == KIND_MARK))
    else $error("bad ordering of a two-result transfer");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.count != 2'd0 && res_o.r0.field_kind == KIND_MARK) |->
      (res_o.r0.out_byte == 8'd0 && res_o.r0.pair_status != 2'd3))
    else $error("malformed pair end marker");

  a_esc_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_PATH) |-> (es_q == ESC_NONE))
    else $error("escape pending in path phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/uqt_res_queue.sv =====
// Three-entry result queue: takes up to two results per cycle while room_o is high;
// hands out one per cycle, unless stalled, from a fixed head register. Depends on uqt_pkg.
`default_nettype none

module uqt_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  uqt_pkg::step_res_t res_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uqt_pkg::out_t      out_data_o
);
  import uqt_pkg::*;

  localparam int unsigned Depth = 3;

  out_t       ent_q [Depth];
  out_t       ent_d [Depth];
  logic [1:0] count_q, count_d;
  logic       pop;
  logic [1:0] base;
  logic [1:0] n_push;

  assign pop    = out_valid_o && out_ready_i;
  assign base   = count_q - {1'b0, pop};
  assign n_push = push_i ? res_i.count : 2'd0;
  // room for two more even without a pop this cycle, decided without out_ready
  assign room_o = (count_q <= 2'd1);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) ent_d[i] = ent_q[i + 1];
      else                      ent_d[i] = ent_q[i];
      if (n_push != 2'd0 && 2'(i) == base)        ent_d[i] = res_i.r0;
      if (n_push == 2'd2 && 2'(i) == base + 2'd1) ent_d[i] = res_i.r1;
    end
    count_d = base + n_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) ent_q[i] <= ent_d[i];
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = ent_q[0];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q <= 2'd1))
    else $error("push without room");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && !pop) |=> (count_q == $past(count_q)))
    else $error("count moved while idle");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 || !room_o)
    else $error("room reported on a full queue");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/url_query_tokenizer_tb.sv =====
// Self-checking testbench for url_query_tokenizer: directed targets, then random request
// targets under several idle/stall phases, checked against an in-bench tokenizer model.
// Depends on uqt_pkg and the url_query_tokenizer RTL.
`default_nettype none

module url_query_tokenizer_tb;
  import uqt_pkg::*;

  localparam int    RANDOM_BYTES = 1150;
  localparam int    MAX_REPORTS  = 10;
  localparam string PATH_POOL    = "abcxyzABCXYZ0189/-._~:";
  localparam string KV_POOL      = "abcdefkqrxyzABFGQZ0259-._~*";
  localparam string NONHEX_POOL  = "gGzZxX_.~!";
  localparam string NOISE_POOL   = "?&=%+";

  typedef enum int {
    MODE_FREE     = 0,
    MODE_SRC_IDLE = 1,
    MODE_SNK_STALL = 2,
    MODE_BOTH     = 3
  } idle_mode_e;

  typedef struct {
    in_t        data;
    idle_mode_e mode;
    bit         hold;
  } target_byte_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  url_query_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  target_byte_t byte_backlog[$];
  out_t         expected_tokens[$];
  out_t         step_tokens[$];
  logic [7:0]   draft[$];

  // tokenizer model state
  phase_e     tok_phase = PH_PATH;
  esc_e       esc_step  = ESC_NONE;
  logic [3:0] hi_nib    = '0;
  logic       pair_open = 1'b0;
  logic       eq_seen   = 1'b0;
  logic       esc_bad   = 1'b0;

  idle_mode_e cur_mode  = MODE_FREE;
  logic       run_en    = 1'b0;
  logic       in_taken  = 1'b0;
  logic       draining  = 1'b0;
  int         errors    = 0;
  int         accepted  = 0;
  int         checked   = 0;
  int         targets   = 0;
  int         marks_kept = 0;
  int         marks_drop = 0;
  int         marks_bad  = 0;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  task automatic emit_token(logic [7:0] b, logic [1:0] kind, logic [1:0] st);
    out_t t;
    t.out_byte     = b;
    t.field_kind   = kind;
    t.pair_status  = st;
    t.last_of_item = 1'b0;
    t.target_done  = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic clear_pair();
    esc_step  = ESC_NONE;
    hi_nib    = '0;
    pair_open = 1'b0;
    eq_seen   = 1'b0;
    esc_bad   = 1'b0;
  endtask

  task automatic close_pair();
    if (esc_step != ESC_NONE) esc_bad = 1'b1;
    if (pair_open) begin
      if (!eq_seen) emit_token(8'h00, KIND_MARK, ST_DROPPED);
      else if (esc_bad) emit_token(8'h00, KIND_MARK, ST_BAD);
      else emit_token(8'h00, KIND_MARK, ST_KEPT);
    end
    clear_pair();
  endtask

  task automatic tokenize_byte(in_t it);
    logic [7:0] c;
    logic [1:0] kind;
    int         h;
    int         n;
    c = it.in_byte;
    step_tokens.delete();
    if (tok_phase == PH_PATH) begin
      if (c == CH_QUEST) begin
        tok_phase = PH_KEY;
        clear_pair();
      end else begin
        emit_token(c, KIND_PATH, ST_KEPT);
      end
    end else if (c == CH_AMP) begin
      close_pair();
      tok_phase = PH_KEY;
    end else begin
      kind = (tok_phase == PH_KEY) ? KIND_KEY : KIND_VALUE;
      pair_open = 1'b1;
      if (tok_phase == PH_KEY && c == CH_EQ) begin
        if (esc_step != ESC_NONE) esc_bad = 1'b1;
        esc_step  = ESC_NONE;
        eq_seen   = 1'b1;
        tok_phase = PH_VALUE;
      end else if (esc_step == ESC_FIRST) begin
        h = hex_nibble(c);
        if (h < 0) begin
          esc_bad  = 1'b1;
          esc_step = ESC_NONE;
        end else begin
          hi_nib   = h[3:0];
          esc_step = ESC_SECOND;
        end
      end else if (esc_step == ESC_SECOND) begin
        h = hex_nibble(c);
        esc_step = ESC_NONE;
        if (h < 0) esc_bad = 1'b1;
        else emit_token({hi_nib, h[3:0]}, kind, ST_KEPT);
      end else if (c == CH_PCT) begin
        esc_step = ESC_FIRST;
      end else if (c == CH_PLUS) begin
        emit_token(CH_SPACE, kind, ST_KEPT);
      end else begin
        emit_token(c, kind, ST_KEPT);
      end
    end
    if (it.end_of_target) begin
      if (tok_phase != PH_PATH) close_pair();
      tok_phase = PH_PATH;
      clear_pair();
    end
    n = step_tokens.size();
    if (n > 0) begin
      step_tokens[n-1].last_of_item = 1'b1;
      step_tokens[n-1].target_done  = it.end_of_target;
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    out_t exp_tok;
    run_en   <= rst_ni;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tokenize_byte(in_data_i);
        accepted <= accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        checked <= checked + 1;
        if (expected_tokens.size() == 0) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("unexpected result: byte=%02h kind=%0d st=%0d last=%0d done=%0d",
                     out_data_o.out_byte, out_data_o.field_kind, out_data_o.pair_status,
                     out_data_o.last_of_item, out_data_o.target_done);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (exp_tok.field_kind == KIND_MARK) begin
            if (exp_tok.pair_status == ST_KEPT) marks_kept <= marks_kept + 1;
            else if (exp_tok.pair_status == ST_DROPPED) marks_drop <= marks_drop + 1;
            else marks_bad <= marks_bad + 1;
          end
          if (out_data_o.out_byte !== exp_tok.out_byte ||
              out_data_o.field_kind !== exp_tok.field_kind ||
              out_data_o.pair_status !== exp_tok.pair_status ||
              out_data_o.last_of_item !== exp_tok.last_of_item ||
              out_data_o.target_done !== exp_tok.target_done) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
              $display("mismatch: exp %02h/%0d/%0d/%0d/%0d got %02h/%0d/%0d/%0d/%0d",
                       exp_tok.out_byte, exp_tok.field_kind, exp_tok.pair_status,
                       exp_tok.last_of_item, exp_tok.target_done,
                       out_data_o.out_byte, out_data_o.field_kind, out_data_o.pair_status,
                       out_data_o.last_of_item, out_data_o.target_done);
          end
        end
      end
    end
  end

  function automatic bit sender_idles(idle_mode_e m);
    if (m == MODE_SRC_IDLE) return $urandom_range(0, 99) < 80;
    if (m == MODE_BOTH) return $urandom_range(0, 99) < 28;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls(idle_mode_e m);
    if (m == MODE_SNK_STALL) return $urandom_range(0, 99) < 80;
    if (m == MODE_BOTH) return $urandom_range(0, 99) < 28;
    return 1'b0;
  endfunction

  // driver: one nonblocking update per signal per falling edge
  always @(negedge clk_i) begin
    target_byte_t nb;
    if (run_en) begin
      if (!in_valid_i || in_taken) begin
        if (byte_backlog.size() != 0 &&
            !(byte_backlog[0].hold && expected_tokens.size() != 0) &&
            !sender_idles(byte_backlog[0].mode)) begin
          nb = byte_backlog.pop_front();
          cur_mode = nb.mode;
          in_valid_i <= 1'b1;
          in_data_i  <= nb.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= draining || !receiver_stalls(cur_mode);
    end
  end

  task automatic push_target(idle_mode_e m, bit hold);
    target_byte_t tb;
    foreach (draft[i]) begin
      tb.data.in_byte       = draft[i];
      tb.data.end_of_target = (i == draft.size() - 1);
      tb.mode               = m;
      tb.hold               = hold && (i == 0);
      byte_backlog.push_back(tb);
    end
    targets++;
  endtask

  task automatic load_string(string s);
    draft.delete();
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_from(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return "0" + 8'(v);
    if ($urandom_range(0, 1) != 0) return "A" + 8'(v - 10);
    return "a" + 8'(v - 10);
  endfunction

  task automatic add_kv_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      draft.push_back(pick_from(KV_POOL));
    end else if (r < 65) begin
      draft.push_back(CH_PLUS);
    end else if (r < 82) begin
      draft.push_back(CH_PCT);
      draft.push_back(pick_hex());
      draft.push_back(pick_hex());
    end else if (r < 88) begin
      // broken escape: non-hex digit, or cut short by whatever follows
      draft.push_back(CH_PCT);
      case ($urandom_range(0, 2))
        0: draft.push_back(pick_from(NONHEX_POOL));
        1: begin
          draft.push_back(pick_hex());
          draft.push_back(pick_from(NONHEX_POOL));
        end
        default: ;
      endcase
    end else if (r < 94) begin
      draft.push_back(8'($urandom));
    end else begin
      draft.push_back(($urandom_range(0, 1) != 0) ? CH_EQ : CH_QUEST);
    end
  endtask

  task automatic build_random_target();
    int         n;
    logic [7:0] b;
    draft.delete();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        draft.push_back(($urandom_range(0, 3) == 0) ? pick_from(NOISE_POOL) : 8'($urandom));
      return;
    end
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (b == CH_QUEST || $urandom_range(0, 5) != 0) b = pick_from(PATH_POOL);
      draft.push_back(b);
    end
    if ($urandom_range(0, 99) < 88) begin
      draft.push_back(CH_QUEST);
      n = $urandom_range(0, 4);
      for (int p = 0; p < n; p++) begin
        if (p > 0) draft.push_back(CH_AMP);
        if ($urandom_range(0, 99) >= 8) begin
          repeat ($urandom_range(0, 3)) add_kv_elem();
          if ($urandom_range(0, 99) < 80) begin
            draft.push_back(CH_EQ);
            repeat ($urandom_range(0, 4)) add_kv_elem();
          end
        end
      end
      if ($urandom_range(0, 99) < 10) draft.push_back(CH_AMP);
    end
    if (draft.size() == 0) draft.push_back(pick_from(PATH_POOL));
  endtask

  initial begin
    int total;
    int random_bytes;
    int ph;
    int last_ph;

    // byte extremes, end on a bare '?'
    draft = {8'h00, 8'hFF, CH_QUEST};
    push_target(MODE_FREE, 1'b0);
    // hex case, '+', dropped pair, empty pair, non-hex digit, escape cut by end
    load_string("p?k=%4a+&n&&=%g&%4");
    push_target(MODE_FREE, 1'b0);
    // escape cut by '=' and by '&', end on the closing '&'
    load_string("?a%4=%F&");
    push_target(MODE_FREE, 1'b0);

    random_bytes = 0;
    last_ph = 0;
    while (random_bytes < RANDOM_BYTES) begin
      ph = random_bytes * 4 / RANDOM_BYTES;
      if (ph > 3) ph = 3;
      build_random_target();
      push_target(idle_mode_e'(ph), ph != last_ph);
      last_ph = ph;
      random_bytes += draft.size();
    end
    total = byte_backlog.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted < total) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    draining = 1'b1;
    repeat (20) @(posedge clk_i);

    $display("covered %0d targets, %0d bytes, %0d results checked", targets, total, checked);
    $display("pair markers: %0d kept, %0d dropped, %0d bad escape; %0d failures",
             marks_kept, marks_drop, marks_bad, errors);
    if (errors == 0) begin
      $display("PASS url_query_tokenizer");
    end else begin
      $display("FAIL url_query_tokenizer");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("FAIL url_query_tokenizer");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/uqt_pkg.sv
rtl/uqt_step.sv
rtl/uqt_res_queue.sv
rtl/url_query_tokenizer.sv
tb/sv/url_query_tokenizer_tb.sv
